FILE: design/urx_pkg.sv
// shared types and constants for the udp/ipv4 receive frame filter
package urx_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 2048;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_PORT = 1'b1;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [3:0]  IP_VERSION_4  = 4'd4;

    localparam int ETH_HDR_LEN   = 14;
    localparam int IP_MIN_HLEN   = 20;
    localparam int UDP_HDR_LEN   = 8;
    localparam int MIN_FRAME_LEN = ETH_HDR_LEN + IP_MIN_HLEN + UDP_HDR_LEN;

    // byte offsets of the fixed header fields
    localparam int OFS_ETYPE    = 12;
    localparam int OFS_VER_IHL  = 14;
    localparam int OFS_TOT_LEN  = 16;
    localparam int OFS_PROTO    = 23;
    localparam int OFS_SRC_ADDR = 26;
    localparam int OFS_DST_ADDR = 30;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [31:0] sender_ip;
        logic [15:0] sender_port;
        logic [6:0]  payload_offset;
        logic [15:0] data_len;
    } t_out_item;

    typedef struct packed {
        logic [15:0] ethertype;
        logic [7:0]  ver_ihl;
        logic [15:0] ip_total_len;
        logic [7:0]  ip_proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] udp_sport;
        logic [15:0] udp_dport;
        logic [15:0] udp_length;
    } t_hdr;

endpackage

FILE: design/urx_capture.sv
// byte counter and header field capture registers
module urx_capture import urx_pkg::*; #(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int CW              = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_in_item      i_item,
    output t_hdr          o_hdr,
    output logic [CW-1:0] o_len,
    output logic          o_overlong
);

    logic [CW-1:0] r_count;
    logic          r_overlong;
    t_hdr          r_hdr;
    logic          w_full;
    logic [CW-1:0] w_udp_ofs;
    logic [7:0]    w_b;

    assign w_full    = (r_count >= CW'(MAX_FRAME_BYTES));
    assign w_udp_ofs = CW'(ETH_HDR_LEN) + CW'({r_hdr.ver_ihl[3:0], 2'b00});
    assign w_b       = i_item.frame_byte;

    // frame length and overflow as they stand once the current byte is counted
    assign o_len      = w_full ? r_count : r_count + CW'(1);
    assign o_overlong = r_overlong | w_full;
    assign o_hdr      = r_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overlong <= 1'b0;
            r_hdr      <= '0;
        end else if (i_en) begin
            if (i_item.last_byte) begin
                r_count    <= '0;
                r_overlong <= 1'b0;
            end else if (w_full) begin
                r_overlong <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
            end
            if (!w_full) begin
                if (r_count == CW'(OFS_ETYPE) || r_count == CW'(OFS_ETYPE + 1)) begin
                    r_hdr.ethertype <= {r_hdr.ethertype[7:0], w_b};
                end
                if (r_count == CW'(OFS_VER_IHL)) begin
                    r_hdr.ver_ihl <= w_b;
                end
                if (r_count == CW'(OFS_TOT_LEN) || r_count == CW'(OFS_TOT_LEN + 1)) begin
                    r_hdr.ip_total_len <= {r_hdr.ip_total_len[7:0], w_b};
                end
                if (r_count == CW'(OFS_PROTO)) begin
                    r_hdr.ip_proto <= w_b;
                end
                if (r_count >= CW'(OFS_SRC_ADDR) && r_count <= CW'(OFS_SRC_ADDR + 3)) begin
                    r_hdr.src_addr <= {r_hdr.src_addr[23:0], w_b};
                end
                if (r_count >= CW'(OFS_DST_ADDR) && r_count <= CW'(OFS_DST_ADDR + 3)) begin
                    r_hdr.dst_addr <= {r_hdr.dst_addr[23:0], w_b};
                end
                // udp header follows the ip options, only looked for past the ver/ihl byte
                if (r_count > CW'(OFS_VER_IHL)) begin
                    if (r_count == w_udp_ofs || r_count == w_udp_ofs + CW'(1)) begin
                        r_hdr.udp_sport <= {r_hdr.udp_sport[7:0], w_b};
                    end
                    if (r_count == w_udp_ofs + CW'(2) || r_count == w_udp_ofs + CW'(3)) begin
                        r_hdr.udp_dport <= {r_hdr.udp_dport[7:0], w_b};
                    end
                    if (r_count == w_udp_ofs + CW'(4) || r_count == w_udp_ofs + CW'(5)) begin
                        r_hdr.udp_length <= {r_hdr.udp_length[7:0], w_b};
                    end
                end
            end
        end
    end

endmodule

FILE: design/urx_verdict.sv
// header checks and result formatting for the final byte of a frame
module urx_verdict import urx_pkg::*; #(
    parameter int CW = 12
) (
    input  t_hdr          i_hdr,
    input  logic [CW-1:0] i_len,
    input  logic          i_overlong,
    input  logic [31:0]   i_local_ip,
    input  logic [15:0]   i_expected_port,
    output t_out_item     o_item
);

    logic [5:0]  w_hlen;
    logic [16:0] w_len;
    logic [16:0] w_total;
    logic [16:0] w_ulen;
    logic [16:0] w_hlen_x;
    logic        w_ok;

    always_comb begin
        w_hlen   = {i_hdr.ver_ihl[3:0], 2'b00};
        w_len    = 17'(i_len);
        w_total  = {1'b0, i_hdr.ip_total_len};
        w_ulen   = {1'b0, i_hdr.udp_length};
        w_hlen_x = 17'(w_hlen);
        // differences are written as sums, the earlier terms already rule out a wrap
        w_ok = !i_overlong
            && (w_len >= 17'(MIN_FRAME_LEN))
            && (i_hdr.ethertype == ETH_TYPE_IPV4)
            && (i_hdr.ver_ihl[7:4] == IP_VERSION_4)
            && (w_hlen_x >= 17'(IP_MIN_HLEN))
            && (w_len >= w_hlen_x + 17'(ETH_HDR_LEN + UDP_HDR_LEN))
            && (i_hdr.ip_proto == IP_PROTO_UDP)
            && (w_total >= w_hlen_x + 17'(UDP_HDR_LEN))
            && (w_total + 17'(ETH_HDR_LEN) <= w_len)
            && (i_hdr.dst_addr == i_local_ip)
            && (i_hdr.udp_dport == i_expected_port)
            && (w_ulen >= 17'(UDP_HDR_LEN))
            && (w_ulen + w_hlen_x <= w_total);

        o_item = '0;
        if (w_ok) begin
            o_item.accepted       = 1'b1;
            o_item.sender_ip      = i_hdr.src_addr;
            o_item.sender_port    = i_hdr.udp_sport;
            o_item.payload_offset = 7'(ETH_HDR_LEN + UDP_HDR_LEN) + 7'(w_hlen);
            o_item.data_len       = i_hdr.udp_length - 16'(UDP_HDR_LEN);
        end
    end

endmodule

FILE: design/udp_ipv4_rx_frame_filter.sv
// top level of the udp/ipv4 receive frame filter
//
// frame bytes enter on the input channel (valid/stall), one byte per item, with
// last_byte set on the final byte. each frame yields exactly one result item on
// the output channel (valid/stall), produced from the final byte: accepted plus
// sender ip, sender port, payload offset and data length, all zero on reject.
// local_ip and expected_port are written through the cfg port (valid/ready,
// always ready) and must only change between frames with nothing in flight.
// throughput: one byte per cycle unless a final byte waits for the output. a
// byte is taken into the input register and from there folded into the capture
// registers; for a final byte the verdict is registered in the output register
// on that same edge, which comes only once the output register is free.
// a stalled result holds in the output register; non-final bytes keep flowing
// into the capture registers meanwhile, and only a final byte waits in the input
// register (raising o_in_stall) until the output register frees.
// reset clears counter, captured fields, config registers and both valid flags.
// frames longer than MAX_FRAME_BYTES are rejected.
module udp_ipv4_rx_frame_filter import urx_pkg::*; #(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    logic          r_in_valid;
    t_in_item      r_in_item;
    logic          r_out_valid;
    t_out_item     r_out_item;
    logic [31:0]   r_local_ip;
    logic [15:0]   r_expected_port;

    logic          w_out_free;
    logic          w_proc;
    logic          w_in_free;
    t_hdr          w_hdr;
    logic [CW-1:0] w_len;
    logic          w_overlong;
    t_out_item     w_verdict;

    assign w_out_free = !r_out_valid || !i_out_stall;
    // a final byte needs a free output slot, other bytes go straight through
    assign w_proc     = r_in_valid && (!r_in_item.last_byte || w_out_free);
    assign w_in_free  = !r_in_valid || w_proc;

    assign o_in_stall  = !w_in_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    urx_capture #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CW              (CW)
    ) u_capture (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_proc),
        .i_item     (r_in_item),
        .o_hdr      (w_hdr),
        .o_len      (w_len),
        .o_overlong (w_overlong)
    );

    // the final byte never lands in a field that an accepting verdict uses,
    // so the checks read the registered fields directly
    urx_verdict #(
        .CW (CW)
    ) u_verdict (
        .i_hdr           (w_hdr),
        .i_len           (w_len),
        .i_overlong      (w_overlong),
        .i_local_ip      (r_local_ip),
        .i_expected_port (r_expected_port),
        .o_item          (w_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= i_in_valid;
        end
        if (w_in_free && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_proc && r_in_item.last_byte;
        end
        if (w_out_free && w_proc && r_in_item.last_byte) begin
            r_out_item <= w_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip      <= '0;
            r_expected_port <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LOCAL_IP:      r_local_ip      <= i_cfg_data[31:0];
                REG_EXPECTED_PORT: r_expected_port <= i_cfg_data[15:0];
                default:           ;
            endcase
        end
    end

endmodule

FILE: design/urx_checker.sv
// port-level checks for the receive frame filter, bound to the top level
module urx_checker import urx_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a rejected frame reports nothing else
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.accepted |->
            o_out_item.sender_ip == '0 && o_out_item.sender_port == '0
            && o_out_item.payload_offset == '0 && o_out_item.data_len == '0)
        else $error("rejected frame with nonzero fields");

    // an accepted frame has at least a minimal ip header and a udp header
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.accepted |->
            o_out_item.payload_offset >= 7'(MIN_FRAME_LEN)
            && o_out_item.payload_offset[1:0] == 2'b10)
        else $error("payload offset out of range");

    // the input only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with a free output");

endmodule

bind udp_ipv4_rx_frame_filter urx_checker u_urx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
